// ===== rtl/b64d_pkg.sv =====
// types, constants and decode helpers shared by the base64 stream decoder
`timescale 1ns / 1ps
package b64d_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;

  localparam logic [7:0] LowerOffset = 8'd26;
  localparam logic [7:0] DigitOffset = 8'd52;
  localparam logic [5:0] PlusSextet  = 6'd62;
  localparam logic [5:0] TopSextet   = 6'd63;

  localparam logic [1:0] GroupDepth = 2'd2;

  // one decoded group: compacted bytes in order from index 0, cnt is 1..3
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } group_t;

  function automatic logic in_alphabet(logic [7:0] c);
    return (c >= CharUpperA && c <= CharUpperZ) || (c >= CharLowerA && c <= CharLowerZ) ||
           (c >= CharZero && c <= CharNine) || c == CharPlus || c == CharSlash ||
           c == CharPad;
  endfunction

  function automatic logic [5:0] sextet_of(logic [7:0] c);
    logic [7:0] v;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      v = c - CharUpperA;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      v = c - CharLowerA + LowerOffset;
    end else if (c >= CharZero && c <= CharNine) begin
      v = c - CharZero + DigitOffset;
    end else if (c == CharPlus) begin
      v = {2'b00, PlusSextet};
    end else begin
      v = {2'b00, TopSextet};
    end
    return v[5:0];
  endfunction

  function automatic group_t make_group(logic [23:0] w, logic pad3, logic pad4);
    group_t g;
    g.bytes[0] = w[23:16];
    g.bytes[1] = pad3 ? w[7:0] : w[15:8];
    g.bytes[2] = w[7:0];
    g.cnt      = 2'd1 + {1'b0, ~pad3} + {1'b0, ~pad4};
    return g;
  endfunction

endpackage

// ===== rtl/b64d_if.sv =====
// valid/ready word channels for characters in and bytes out
`timescale 1ns / 1ps
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       run_last;

  modport source (output valid, output data_byte, output run_last, input ready);
  modport sink (input valid, input data_byte, input run_last, output ready);
endinterface

// ===== rtl/b64d_group_asm.sv =====
// character decode and group assembly with end-of-text flush
`timescale 1ns / 1ps
module b64d_group_asm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      text_char_i,
  input  logic            end_of_text_i,
  output logic            push_o,
  output b64d_pkg::group_t group_o
);
  import b64d_pkg::*;

  logic [1:0]  fill_q, fill_d, fill_mid;
  logic [17:0] held_q, held_d, held_mid;
  logic        twp_q, twp_d, twp_mid;
  logic        char_ok, char_pad, grp_v;
  logic [5:0]  sextet;
  logic [23:0] flush_w;
  group_t      grp;

  always_comb begin
    char_ok  = in_alphabet(text_char_i);
    char_pad = (text_char_i == CharPad);
    sextet   = sextet_of(text_char_i);
    fill_mid = fill_q;
    held_mid = held_q;
    twp_mid  = twp_q;
    grp      = make_group({held_q, sextet}, twp_q, char_pad);
    grp_v    = 1'b0;
    flush_w  = {held_q, 6'd0};
    if (char_ok) begin
      if (fill_q != 2'd3) begin
        held_mid = {held_q[11:0], sextet};
        fill_mid = fill_q + 2'd1;
        if (fill_q == 2'd2) begin
          twp_mid = char_pad;
        end
      end else begin
        grp_v    = 1'b1;
        fill_mid = 2'd0;
        held_mid = 18'd0;
        twp_mid  = 1'b0;
      end
    end
    case (fill_mid)
      2'd1:    flush_w = {held_mid[5:0], 18'd0};
      2'd2:    flush_w = {held_mid[11:0], 12'd0};
      default: flush_w = {held_mid, 6'd0};
    endcase
    fill_d = fill_mid;
    held_d = held_mid;
    twp_d  = twp_mid;
    if (end_of_text_i) begin
      if (fill_mid != 2'd0) begin
        grp   = make_group(flush_w, (fill_mid == 2'd3) && twp_mid, 1'b0);
        grp_v = 1'b1;
      end
      fill_d = 2'd0;
      held_d = 18'd0;
      twp_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      held_q <= 18'd0;
      twp_q  <= 1'b0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      held_q <= held_d;
      twp_q  <= twp_d;
    end
  end

  assign push_o  = accept_i && grp_v;
  assign group_o = grp;

endmodule

// ===== rtl/base64_stream_decoder_unit.sv =====
// top level of the streaming base64 decoder
`timescale 1ns / 1ps
// Streaming base64 decoder. One character word is taken per clock cycle; a character
// outside A-Z a-z 0-9 + / = is dropped, and a set end_of_text flag flushes a partial
// group padded with 'A'. Each completed or flushed group is decoded in the cycle its
// character is taken and written into a two-entry group queue, from which bytes leave
// one per cycle while the receiver is ready, with run_last on the final byte of each
// group. The input side stalls only while both queue entries hold groups, so ordinary
// text runs at one character per cycle; a run of flushes can produce up to three bytes
// per character, and then the one-byte output port sets the pace.
module base64_stream_decoder_unit (
  input  logic clk_i,
  input  logic rst_ni,
  b64d_in_if.sink    in_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  group_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       in_acc, push, pop, out_acc, is_last;
  group_t     grp, head;

  assign in_i.ready = (cnt_q != GroupDepth);
  assign in_acc     = in_i.valid && in_i.ready;

  b64d_group_asm u_asm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .text_char_i   (in_i.text_char),
    .end_of_text_i (in_i.end_of_text),
    .push_o        (push),
    .group_o       (grp)
  );

  assign head            = mem_q[rd_ptr_q];
  assign is_last         = ((idx_q + 2'd1) == head.cnt);
  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.data_byte = head.bytes[idx_q];
  assign out_o.run_last  = is_last;
  assign out_acc         = out_o.valid && out_o.ready;
  assign pop             = out_acc && is_last;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
    idx_d = idx_q;
    if (out_acc) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= GroupDepth)
    else $error("group queue count out of range");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != GroupDepth))
    else $error("group written into a full queue");

  a_group_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (grp.cnt != 2'd0))
    else $error("group with no bytes written");

  a_idx_in_group : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (idx_q < head.cnt))
    else $error("byte index past end of group");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd0) || (cnt_q == GroupDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the streaming base64 decoder
`timescale 1ns / 1ps
module testbench;
  import b64d_pkg::*;

  class b64_scoreboard;
    typedef struct packed {
      logic [7:0] data_byte;
      logic       run_last;
    } out_word_t;

    out_word_t  expected_bytes[$];
    logic [1:0] fill;
    logic [17:0] held;
    logic       third_pad;

    function new();
      clear_group();
    endfunction

    function void clear_group();
      fill      = 2'd0;
      held      = 18'd0;
      third_pad = 1'b0;
    endfunction

    function bit is_b64_char(logic [7:0] c);
      return (c >= CharUpperA && c <= CharUpperZ) || (c >= CharLowerA && c <= CharLowerZ) ||
             (c >= CharZero && c <= CharNine) || c == CharPlus || c == CharSlash ||
             c == CharPad;
    endfunction

    function logic [5:0] char_value(logic [7:0] c);
      logic [7:0] v;
      if (c >= CharUpperA && c <= CharUpperZ) begin
        v = c - CharUpperA;
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
        v = c - CharLowerA + 8'd26;
      end else if (c >= CharZero && c <= CharNine) begin
        v = c - CharZero + 8'd52;
      end else if (c == CharPlus) begin
        v = 8'd62;
      end else begin
        v = 8'd63;
      end
      return v[5:0];
    endfunction

    function void add_expected(out_word_t e);
      expected_bytes.insert(expected_bytes.size(), e);
    endfunction

    function void push_group(logic [23:0] w, bit pad3, bit pad4);
      out_word_t e;
      e.data_byte = w[23:16];
      e.run_last  = pad3 && pad4;
      add_expected(e);
      if (!pad3) begin
        e.data_byte = w[15:8];
        e.run_last  = pad4;
        add_expected(e);
      end
      if (!pad4) begin
        e.data_byte = w[7:0];
        e.run_last  = 1'b1;
        add_expected(e);
      end
    endfunction

    function void note_word(logic [7:0] c, logic eot);
      logic [5:0] v;
      bit pad;
      if (is_b64_char(c)) begin
        v   = char_value(c);
        pad = (c == CharPad);
        if (fill < 2'd3) begin
          if (fill == 2'd2) third_pad = pad;
          held = {held[11:0], v};
          fill = fill + 2'd1;
        end else begin
          push_group({held, v}, third_pad, pad);
          clear_group();
        end
      end
      if (eot) begin
        // partial group is completed with zero sextets
        case (fill)
          2'd1: push_group({held[5:0], 18'd0}, 1'b0, 1'b0);
          2'd2: push_group({held[11:0], 12'd0}, 1'b0, 1'b0);
          2'd3: push_group({held, 6'd0}, third_pad, 1'b0);
          default: ;
        endcase
        clear_group();
      end
    endfunction

    function string check_byte(logic [7:0] d, logic l);
      out_word_t e;
      string s;
      s = "";
      if (expected_bytes.size() == 0) begin
        return $sformatf("unexpected word data_byte=%02h run_last=%0b", d, l);
      end
      e = expected_bytes.pop_front();
      if (d !== e.data_byte) begin
        s = $sformatf("data_byte got %02h want %02h ", d, e.data_byte);
      end
      if (l !== e.run_last) begin
        s = {s, $sformatf("run_last got %0b want %0b", l, e.run_last)};
      end
      return s;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   mismatch_count;
  b64_scoreboard sb;

  b64d_in_if  in_ch();
  b64d_out_if out_ch();

  base64_stream_decoder_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("[base64_stream_decoder_unit] ERROR");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // receiver stall pattern, reloaded at random each time the phase counter wraps
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_phase = 4'd0;

  always @(negedge clk) begin
    out_ch.ready <= ready_pattern[ready_phase];
    ready_phase  <= ready_phase + 4'd1;
    if (ready_phase == 4'd15) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom);
        2: ready_pattern <= 16'($urandom) | 16'($urandom);
        default: ready_pattern <= 16'($urandom) & 16'($urandom);
      endcase
    end
  end

  always @(posedge clk) begin : byte_monitor
    string msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      msg = sb.check_byte(out_ch.data_byte, out_ch.run_last);
      if (msg.len() != 0) report_mismatch(msg);
    end
  end

  task automatic send_word(logic [7:0] c, logic eot);
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.text_char   <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(c, eot);
  endtask

  task automatic send_text(string s, bit eot_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      idx = $urandom_range(0, 63);
      if (idx < 26) return CharUpperA + 8'(idx);
      if (idx < 52) return CharLowerA + 8'(idx - 26);
      if (idx < 62) return CharZero + 8'(idx - 52);
      if (idx == 62) return CharPlus;
      return CharSlash;
    end
    if (r < 82) return CharPad;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    logic [7:0] c;
    logic       eot;
    int         counted;
    int         burst_left;
    mismatch_count    = 0;
    sb                = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_char   = 8'd0;
    in_ch.end_of_text = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("TWFu", 1'b0);
    send_text("QQ==", 1'b0);
    send_text("QUI=", 1'b0);
    send_text("/", 1'b1);
    send_text("Zm", 1'b1);
    send_text("Zm=", 1'b1);
    send_word(8'h00, 1'b1);
    send_text("ab", 1'b0);
    send_word(8'hFF, 1'b1);
    send_text("09+z", 1'b1);
    wait_drained();

    counted    = 0;
    burst_left = 0;
    while (counted < 150) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end
      if (counted == 75) wait_drained();
      c   = pick_char();
      eot = ($urandom_range(0, 11) == 0);
      send_word(c, eot);
      counted++;
      burst_left--;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && sb.pending() == 0) begin
      $display("[base64_stream_decoder_unit] OK");
    end else begin
      $display("[base64_stream_decoder_unit] ERROR");
    end
    $finish;
  end
endmodule
